FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition never holds at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/rwrp_pkg.sv
`default_nettype none
package rwrp_pkg;

  localparam int MAX_NODES = 16;
  localparam int FRAC_BITS = 15;

  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int W_W       = 16;
  localparam int TOT_W     = W_W + IDX_W;
  localparam int PROB_W    = FRAC_BITS + 1;
  localparam int MUL_W     = 2 * PROB_W;
  localparam int ACC_W     = MUL_W + IDX_W;
  localparam int SUM_W     = PROB_W + 2;
  localparam int DIVC_W    = $clog2(PROB_W);
  localparam int DRAIN_LEN = MAX_NODES + 4;
  localparam int DRN_W     = $clog2(DRAIN_LEN + 1);

  localparam logic [PROB_W-1:0] ONE_FX = PROB_W'(1) << FRAC_BITS;

  localparam logic CFG_WALK_STEPS = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_NORM_RD,
    ST_NORM_LD,
    ST_NORM_DIV,
    ST_NORM_WR,
    ST_STEP_FEED,
    ST_STEP_DRAIN,
    ST_FINISH
  } state_t;

  // one D entry traveling down the cell chain
  typedef struct packed {
    logic              v;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  k;
    logic [PROB_W-1:0] d;
  } feed_t;

  // transition entry load into one column cell
  typedef struct packed {
    logic              v;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [PROB_W-1:0] p;
  } load_t;

  // finished product entry from a cell
  typedef struct packed {
    logic              v;
    logic [IDX_W-1:0]  row;
    logic [PROB_W-1:0] d;
  } res_t;

  function automatic logic [PROB_W-1:0] clamp_acc(input logic [ACC_W-1:0] v);
    if (v > {{(ACC_W-PROB_W){1'b0}}, ONE_FX}) return ONE_FX;
    return v[PROB_W-1:0];
  endfunction

  function automatic logic [PROB_W-1:0] clamp_sum(input logic [SUM_W-1:0] v);
    if (v > {{(SUM_W-PROB_W){1'b0}}, ONE_FX}) return ONE_FX;
    return v[PROB_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/random_walk_reach_probability.sv
// Random-walk reach probability engine.
// Input channel (in_valid/in_stall) carries commands: write weight, run, read.
// A write beat stores one adjacency weight and gives no result. A read beat
// returns S[row][col] on the out channel in the next cycle, with out_run_done
// low; reads and writes stream one beat per cycle while the engine is idle.
// A run beat blocks the input while the engine works, then posts one result
// with out_run_done high and out_reach_prob zero. A run first forms the row
// sums and normalizes each weight by one-bit-per-cycle division, then does
// walk_steps-1 matrix products with N = MAX_NODES: the N*N entries of D
// enter a chain of N column cells one per cycle, each cell doing one
// multiply-accumulate and the S update.
// Configuration (cfg_valid/cfg_ready, always ready) sets walk_steps and
// node_count; write it only while no command is in flight.
// Reset clears control state and sets walk_steps 1, node_count 16; the
// matrix stores are undefined until written or run.
// A stalled result holds in the output register; a write beat is still taken
// then, run and read beats wait until the result leaves.
`default_nettype none
`include "assert_macros.svh"
module random_walk_reach_probability (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic [15:0] in_edge_weight,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_reach_prob,
  output logic        out_run_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import rwrp_pkg::*;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  sum_cnt_r, sum_cnt_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [IDX_W-1:0]  feed_row_r, feed_row_nxt;
  logic [IDX_W-1:0]  feed_k_r, feed_k_nxt;
  logic [DRN_W-1:0]  drain_r, drain_nxt;
  logic [7:0]        step_r, step_nxt;
  logic              bank_r, bank_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [7:0]        steps_r, steps_nxt;
  logic [PROB_W-1:0] p_r, p_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_prob_r, out_prob_nxt;
  logic              out_done_r, out_done_nxt;
  logic [7:0]        walk_steps_r;
  logic [6:0]        node_count_r;

  logic              feed_v_r;
  logic [IDX_W-1:0]  feed_row_d_r;
  logic [IDX_W-1:0]  feed_k_d_r;
  logic [W_W-1:0]    wq_r;
  logic [PROB_W-1:0] dist_q_r;

  logic [W_W-1:0]    wmem [MEM_DEPTH];
  logic [PROB_W-1:0] dist_mem [2*MEM_DEPTH];

  logic              in_acc;
  logic              in_range;
  logic [ADDR_W-1:0] w_raddr;
  logic [ADDR_W:0]   dist_raddr;
  logic              dist_we;
  logic [ADDR_W:0]   dist_waddr;
  logic [PROB_W-1:0] dist_wdata;
  load_t             ld;
  logic              div_start;
  logic              div_done;
  logic [PROB_W-1:0] div_quot;

  feed_t             chain [MAX_NODES+1];
  res_t              cell_res [MAX_NODES];
  logic [PROB_W-1:0] cell_rd [MAX_NODES];
  logic [MAX_NODES-1:0] res_vec;
  logic              res_any;
  logic [IDX_W-1:0]  res_row;
  logic [IDX_W-1:0]  res_col;
  logic [PROB_W-1:0] res_d;

  assign in_range = (int'(in_row_index) < MAX_NODES) && (int'(in_col_index) < MAX_NODES);
  assign in_stall = (state_r != ST_IDLE) ||
                    (out_valid_r && out_stall && in_cmd != CMD_WRITE);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_steps_r <= 8'd1;
      node_count_r <= 7'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WALK_STEPS: walk_steps_r <= cfg_data;
        CFG_NODE_COUNT: node_count_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  rwrp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (wq_r),
    .divisor  (total_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign chain[0] = '{v: feed_v_r, row: feed_row_d_r, k: feed_k_d_r, d: dist_q_r};

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    rwrp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_col  (IDX_W'(g)),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .ld        (ld),
      .rd_row    (in_row_index[IDX_W-1:0]),
      .rd_data   (cell_rd[g]),
      .res       (cell_res[g])
    );
  end

  always_comb begin
    res_any = 1'b0;
    res_row = '0;
    res_col = '0;
    res_d   = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      res_vec[i] = cell_res[i].v;
      res_any    = res_any | cell_res[i].v;
      res_row    = res_row | (cell_res[i].v ? cell_res[i].row : '0);
      res_col    = res_col | (cell_res[i].v ? IDX_W'(i) : '0);
      res_d      = res_d | (cell_res[i].v ? cell_res[i].d : '0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sum_cnt_nxt   = sum_cnt_r;
    total_nxt     = total_r;
    feed_row_nxt  = feed_row_r;
    feed_k_nxt    = feed_k_r;
    drain_nxt     = drain_r;
    step_nxt      = step_r;
    bank_nxt      = bank_r;
    n_nxt         = n_r;
    steps_nxt     = steps_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_prob_nxt  = out_prob_r;
    out_done_nxt  = out_done_r;
    w_raddr       = {row_r, col_r};
    dist_raddr    = {bank_r, feed_row_r, feed_k_r};
    dist_we       = res_any;
    dist_waddr    = {~bank_r, res_row, res_col};
    dist_wdata    = res_d;
    ld            = '0;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_RUN: begin
              if (node_count_r == '0) n_nxt = CNT_W'(1);
              else if (int'(node_count_r) > MAX_NODES) n_nxt = CNT_W'(MAX_NODES);
              else n_nxt = CNT_W'(node_count_r);
              steps_nxt   = (walk_steps_r == '0) ? 8'd1 : walk_steps_r;
              row_nxt     = '0;
              sum_cnt_nxt = '0;
              total_nxt   = '0;
              bank_nxt    = 1'b0;
              step_nxt    = 8'd1;
              state_nxt   = ST_SUM;
            end
            CMD_READ: begin
              out_valid_nxt = 1'b1;
              out_prob_nxt  = in_range ? 16'(cell_rd[in_col_index[IDX_W-1:0]]) : 16'd0;
              out_done_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SUM: begin
        w_raddr = {row_r, sum_cnt_r[IDX_W-1:0]};
        if (sum_cnt_r != '0 && (sum_cnt_r - CNT_W'(1)) < n_r && CNT_W'(row_r) < n_r) begin
          total_nxt = total_r + TOT_W'(wq_r);
        end
        if (sum_cnt_r == CNT_W'(MAX_NODES)) begin
          col_nxt   = '0;
          state_nxt = ST_NORM_RD;
        end else begin
          sum_cnt_nxt = sum_cnt_r + CNT_W'(1);
        end
      end
      ST_NORM_RD: begin
        state_nxt = ST_NORM_LD;
      end
      ST_NORM_LD: begin
        if (CNT_W'(row_r) < n_r && CNT_W'(col_r) < n_r && total_r != '0) begin
          div_start = 1'b1;
          state_nxt = ST_NORM_DIV;
        end else begin
          p_nxt     = '0;
          state_nxt = ST_NORM_WR;
        end
      end
      ST_NORM_DIV: begin
        if (div_done) begin
          p_nxt     = (div_quot > ONE_FX) ? ONE_FX : div_quot;
          state_nxt = ST_NORM_WR;
        end
      end
      ST_NORM_WR: begin
        ld         = '{v: 1'b1, row: row_r, col: col_r, p: p_r};
        dist_we    = 1'b1;
        dist_waddr = {1'b0, row_r, col_r};
        dist_wdata = p_r;
        if (col_r == IDX_W'(MAX_NODES - 1)) begin
          col_nxt = '0;
          if (row_r == IDX_W'(MAX_NODES - 1)) begin
            feed_row_nxt = '0;
            feed_k_nxt   = '0;
            state_nxt    = (steps_r == 8'd1) ? ST_FINISH : ST_STEP_FEED;
          end else begin
            row_nxt     = row_r + IDX_W'(1);
            sum_cnt_nxt = '0;
            total_nxt   = '0;
            state_nxt   = ST_SUM;
          end
        end else begin
          col_nxt   = col_r + IDX_W'(1);
          state_nxt = ST_NORM_RD;
        end
      end
      ST_STEP_FEED: begin
        if (feed_k_r == IDX_W'(MAX_NODES - 1)) begin
          feed_k_nxt = '0;
          if (feed_row_r == IDX_W'(MAX_NODES - 1)) begin
            drain_nxt = '0;
            state_nxt = ST_STEP_DRAIN;
          end else begin
            feed_row_nxt = feed_row_r + IDX_W'(1);
          end
        end else begin
          feed_k_nxt = feed_k_r + IDX_W'(1);
        end
      end
      ST_STEP_DRAIN: begin
        if (drain_r == DRN_W'(DRAIN_LEN - 1)) begin
          bank_nxt = ~bank_r;
          if (step_r == steps_r - 8'd1) begin
            state_nxt = ST_FINISH;
          end else begin
            step_nxt     = step_r + 8'd1;
            feed_row_nxt = '0;
            feed_k_nxt   = '0;
            state_nxt    = ST_STEP_FEED;
          end
        end else begin
          drain_nxt = drain_r + DRN_W'(1);
        end
      end
      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        out_prob_nxt  = 16'd0;
        out_done_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      feed_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      feed_v_r    <= state_r == ST_STEP_FEED;
    end
  end

  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    sum_cnt_r    <= sum_cnt_nxt;
    total_r      <= total_nxt;
    feed_row_r   <= feed_row_nxt;
    feed_k_r     <= feed_k_nxt;
    drain_r      <= drain_nxt;
    step_r       <= step_nxt;
    bank_r       <= bank_nxt;
    n_r          <= n_nxt;
    steps_r      <= steps_nxt;
    p_r          <= p_nxt;
    out_prob_r   <= out_prob_nxt;
    out_done_r   <= out_done_nxt;
    feed_row_d_r <= feed_row_r;
    feed_k_d_r   <= feed_k_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_WRITE && in_range) begin
      wmem[{in_row_index[IDX_W-1:0], in_col_index[IDX_W-1:0]}] <= in_edge_weight;
    end
    wq_r <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_q_r <= dist_mem[dist_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_reach_prob = out_prob_r;
  assign out_run_done   = out_done_r;

  `ASSERT_ALWAYS(a_accept_idle, (in_valid && !in_stall) |-> (state_r == ST_IDLE), "beat taken while busy")
  `ASSERT_ALWAYS(a_one_result, $onehot0(res_vec), "two cells finished in one cycle")
  `ASSERT_NEVER(a_result_phase, res_any && state_r != ST_STEP_FEED && state_r != ST_STEP_DRAIN, "cell result outside product phase")
  `ASSERT_ALWAYS(a_div_phase, div_done |-> (state_r == ST_NORM_DIV), "divider done outside divide wait")

endmodule
`default_nettype wire

FILE: rtl/rwrp_div.sv
`default_nettype none
module rwrp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rwrp_pkg::W_W-1:0]    dividend,
  input  logic [rwrp_pkg::TOT_W-1:0]  divisor,
  output logic                      done,
  output logic [rwrp_pkg::PROB_W-1:0] quot
);
  import rwrp_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIVC_W-1:0] cnt_r;
  logic [TOT_W:0]    rem_r;
  logic [TOT_W-1:0]  dsr_r;
  logic [PROB_W-1:0] q_r;
  logic [TOT_W:0]    trial;
  logic              ge;

  // first step yields the integer bit, then one fraction bit per cycle
  always_comb begin
    trial = (cnt_r == '0) ? rem_r : (rem_r << 1);
    ge    = trial >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIVC_W'(FRAC_BITS)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (TOT_W+1)'(dividend);
      dsr_r <= divisor;
      cnt_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (trial - {1'b0, dsr_r}) : trial;
      q_r   <= {q_r[PROB_W-2:0], ge};
      cnt_r <= cnt_r + DIVC_W'(1);
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

FILE: rtl/rwrp_cell.sv
`default_nettype none
module rwrp_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rwrp_pkg::IDX_W-1:0]  cell_col,
  input  rwrp_pkg::feed_t             chain_in,
  output rwrp_pkg::feed_t             chain_out,
  input  rwrp_pkg::load_t             ld,
  input  logic [rwrp_pkg::IDX_W-1:0]  rd_row,
  output logic [rwrp_pkg::PROB_W-1:0] rd_data,
  output rwrp_pkg::res_t              res
);
  import rwrp_pkg::*;

  logic [PROB_W-1:0] p_mem [MAX_NODES];
  logic [PROB_W-1:0] s_mem [MAX_NODES];

  feed_t             pass_r;
  logic [ACC_W-1:0]  acc_r;
  logic              dq_v_r;
  logic [IDX_W-1:0]  dq_row_r;
  logic [PROB_W-1:0] dq_r;

  logic [MUL_W-1:0]  prod;
  logic [ACC_W-1:0]  sum;
  logic [IDX_W-1:0]  s_addr;
  logic [PROB_W-1:0] s_old;
  logic [PROB_W-1:0] s_gap;
  logic [MUL_W-1:0]  s_prod;
  logic [SUM_W-1:0]  s_tot;
  logic [PROB_W-1:0] s_new;
  logic              last_k;

  always_comb begin
    prod   = MUL_W'(chain_in.d) * MUL_W'(p_mem[chain_in.k]);
    sum    = ((chain_in.k == '0) ? '0 : acc_r) + ACC_W'(prod);
    last_k = chain_in.k == IDX_W'(MAX_NODES - 1);
    s_addr = dq_v_r ? dq_row_r : rd_row;
    s_old  = s_mem[s_addr];
    s_gap  = ONE_FX - s_old;
    s_prod = MUL_W'(dq_r) * MUL_W'(s_gap);
    s_tot  = SUM_W'(s_old) + SUM_W'(s_prod >> FRAC_BITS);
    s_new  = clamp_sum(s_tot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r.v <= 1'b0;
      dq_v_r   <= 1'b0;
    end else begin
      pass_r   <= chain_in;
      dq_v_r   <= chain_in.v && last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_in.v) begin
      acc_r <= sum;
    end
    if (chain_in.v && last_k) begin
      dq_r     <= clamp_acc(sum >> FRAC_BITS);
      dq_row_r <= chain_in.row;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.v && ld.col == cell_col) begin
      p_mem[ld.row] <= ld.p;
      s_mem[ld.row] <= ld.p;
    end else if (dq_v_r) begin
      s_mem[dq_row_r] <= s_new;
    end
  end

  assign chain_out = pass_r;
  assign rd_data   = s_old;
  assign res       = '{v: dq_v_r, row: dq_row_r, d: dq_r};

endmodule
`default_nettype wire

FILE: tb/sv/random_walk_reach_probability_tb.sv
`default_nettype none
module random_walk_reach_probability_tb;
  import rwrp_pkg::*;

  localparam int NMAX = 16;
  localparam longint ONE_Q = 64'd1 << 15;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [5:0]  in_row_index;
  logic [5:0]  in_col_index;
  logic [15:0] in_edge_weight;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_reach_prob;
  logic        out_run_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  random_walk_reach_probability dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_edge_weight(in_edge_weight),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_reach_prob(out_reach_prob), .out_run_done(out_run_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct {
    logic [15:0] prob;
    logic        done;
  } reach_result_t;

  reach_result_t pending_q[$];
  logic [15:0]   weights[NMAX*NMAX];
  longint        trans_m[NMAX*NMAX];
  longint        dist_m[NMAX*NMAX];
  longint        sum_m[NMAX*NMAX];
  logic [7:0]    steps_reg;
  logic [6:0]    nodes_reg;
  bit            failed;
  bit            quiet;
  longint        cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd30000000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint clamp1(longint v);
    return v > ONE_Q ? ONE_Q : v;
  endfunction

  task automatic compute_walk();
    int n, st;
    longint tot, acc;
    longint prod[NMAX*NMAX];
    n = nodes_reg < 1 ? 1 : (nodes_reg > NMAX ? NMAX : nodes_reg);
    st = steps_reg < 1 ? 1 : steps_reg;
    foreach (trans_m[i]) trans_m[i] = 0;
    for (int r = 0; r < n; r++) begin
      tot = 0;
      for (int c = 0; c < n; c++) tot += weights[r*NMAX+c];
      if (tot != 0)
        for (int c = 0; c < n; c++)
          trans_m[r*NMAX+c] = clamp1((longint'(weights[r*NMAX+c]) << 15) / tot);
    end
    dist_m = trans_m;
    sum_m = trans_m;
    for (int s = 1; s < st; s++) begin
      foreach (prod[i]) prod[i] = 0;
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) begin
          acc = 0;
          for (int k = 0; k < n; k++) acc += dist_m[r*NMAX+k] * trans_m[k*NMAX+c];
          prod[r*NMAX+c] = clamp1(acc >> 15);
        end
      dist_m = prod;
      for (int i = 0; i < NMAX*NMAX; i++)
        sum_m[i] = clamp1(sum_m[i] + ((dist_m[i] * (ONE_Q - sum_m[i])) >> 15));
    end
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  // in_valid stays high after the beat until the next idle gap or drain
  task automatic send_beat(cmd_t c, int r, int col, int w);
    reach_result_t e;
    idle_gap();
    in_valid <= 1'b1;
    in_cmd <= c;
    in_row_index <= r[5:0];
    in_col_index <= col[5:0];
    in_edge_weight <= w[15:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (c)
      CMD_WRITE: if (r < NMAX && col < NMAX) begin
        weights[r*NMAX+col] = w[15:0];
      end
      CMD_RUN: begin
        compute_walk();
        e.prob = 16'd0; e.done = 1'b1;
        pending_q.push_back(e);
      end
      CMD_READ: begin
        e.prob = (r < NMAX && col < NMAX) ? sum_m[r*NMAX+col][15:0] : 16'd0;
        e.done = 1'b0;
        pending_q.push_back(e);
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: actual prob=%0d done=%0d", $time,
                 out_reach_prob, out_run_done);
        failed = 1;
      end else begin
        if (pending_q[0].prob !== out_reach_prob || pending_q[0].done !== out_run_done) begin
          $display("%0t mismatch: expected prob=%0d done=%0d actual prob=%0d done=%0d",
                   $time, pending_q[0].prob, pending_q[0].done, out_reach_prob, out_run_done);
          failed = 1;
        end
        void'(pending_q.pop_front());
      end
    end
  end

  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[7:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_WALK_STEPS) steps_reg = v[7:0]; else nodes_reg = v[6:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_all(int mode);
    for (int r = 0; r < NMAX; r++)
      for (int c = 0; c < NMAX; c++) begin
        int w;
        case (mode)
          0: w = 0;
          1: w = 16'hFFFF;
          default: w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 65535);
        endcase
        if (mode == 3 && r == 2) w = 0;
        send_beat(CMD_WRITE, r, c, w);
      end
  endtask

  task automatic read_some(int cnt);
    for (int i = 0; i < cnt; i++) begin
      int r, c;
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
      if ($urandom_range(0, 3) != 0) begin r = r % NMAX; c = c % NMAX; end
      send_beat(CMD_READ, r, c, $urandom);
    end
  endtask

  task automatic test_directed();
    load_all(1);
    send_beat(CMD_WRITE, 63, 0, 16'h1234);
    send_beat(CMD_WRITE, 0, 63, 16'h4321);
    send_beat(CMD_WRITE, 3, 5, 0);
    send_beat(cmd_t'(2'd3), 1, 1, 16'hAAAA);
    send_beat(CMD_RUN, 0, 0, 0);
    send_beat(CMD_READ, 0, 0, 0);
    send_beat(CMD_READ, 15, 15, 0);
    send_beat(CMD_READ, 3, 5, 0);
    send_beat(CMD_READ, 63, 63, 0);
    send_beat(CMD_READ, 0, 42, 0);
    send_beat(CMD_READ, 21, 0, 0);
  endtask

  task automatic test_zero_rows();
    load_all(3);
    write_cfg(CFG_WALK_STEPS, 3);
    send_beat(CMD_RUN, 0, 0, 0);
    for (int c = 0; c < NMAX; c++) send_beat(CMD_READ, 2, c, 0);
    load_all(0);
    send_beat(CMD_RUN, 0, 0, 0);
    read_some(8);
  endtask

  task automatic test_config_sweep();
    int steps_set[6] = '{0, 1, 2, 5, 255, 9};
    int nodes_set[6] = '{0, 1, 2, 64, 16, 7};
    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_WALK_STEPS, steps_set[p]);
      write_cfg(CFG_NODE_COUNT, nodes_set[p]);
      if (p == 0) load_all(2);
      send_beat(CMD_RUN, $urandom, $urandom, $urandom);
      read_some(20);
    end
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 250; i++) begin
      int k;
      k = $urandom_range(0, 19);
      if (k < 9) send_beat(CMD_WRITE, $urandom_range(0, 17), $urandom_range(0, 17), $urandom);
      else if (k < 18) read_some(1);
      else if (k == 18) send_beat(cmd_t'(2'd3), $urandom, $urandom, $urandom);
      else begin
        drain();
        write_cfg(CFG_WALK_STEPS, $urandom_range(1, 6));
        write_cfg(CFG_NODE_COUNT, $urandom_range(1, 16));
        send_beat(CMD_RUN, 0, 0, 0);
      end
      if (i == 200) quiet = 1;
    end
  endtask

  initial begin
    failed = 0; quiet = 0; cycles = 0;
    steps_reg = 1; nodes_reg = 16;
    foreach (weights[i]) begin
      weights[i] = 0; trans_m[i] = 0; dist_m[i] = 0; sum_m[i] = 0;
    end
    rst_n = 0;
    in_valid = 0; in_cmd = CMD_WRITE; in_row_index = 0; in_col_index = 0;
    in_edge_weight = 0; cfg_valid = 0; cfg_index = CFG_WALK_STEPS; cfg_data = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_zero_rows();
    test_config_sweep();
    test_random_mix();
    drain();
    repeat (50) @(negedge clk);
    if (!failed && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/rwrp_pkg.sv
rtl/rwrp_div.sv
rtl/rwrp_cell.sv
rtl/random_walk_reach_probability.sv
tb/sv/random_walk_reach_probability_tb.sv
